### rtl/core/bbrm_pkg.sv
// Shared types, codes and defaults for the byte buffer with read modes.
package bbrm_pkg;

   localparam int DEPTH_DEFAULT   = 1024;
   localparam int MAX_RUN_DEFAULT = 64;

   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 11;
   localparam int RLEN_W   = 7;
   localparam int MODE_W   = 2;
   localparam int CAP_W    = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [MODE_W-1:0] MODE_FULL    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PARTIAL = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ_ADDR,
      ST_READ_DATA,
      ST_SEND
   } state_type;

endpackage

### rtl/core/bbrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/byte_buffer_with_read_modes_unit.sv
// Top level of the byte buffer: circular store, head pointer, fill count and read sequencer.
//
//   channel | direction | handshake             | carries
//   req_    | in        | req_valid / req_stall | action, byte, chunk info, read length and mode
//   rsp_    | out       | rsp_valid / rsp_stall | one byte per transfer, last flag, run count
//   csr_    | in        | csr_valid / csr_ready | capacity_in_use
//
// A write byte passes through the write state; a clear or ignored action completes in idle.
// A read steps through address, registered RAM read and send for each delivered byte,
// or address and send for the empty result, and waits in send while the rsp_ side stalls.
// Reset clears head and fill and sets capacity to 1024; store contents are not cleared.
// req_stall is high from accepting a write or read until it is done; clears never raise it.
module byte_buffer_with_read_modes_unit #(
   parameter int DEPTH   = bbrm_pkg::DEPTH_DEFAULT,
   parameter int MAX_RUN = bbrm_pkg::MAX_RUN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bbrm_pkg::ACTION_W-1:0] req_action,
   input  logic [bbrm_pkg::BYTE_W-1:0]   req_write_byte,
   input  logic                          req_chunk_first,
   input  logic [bbrm_pkg::LEN_W-1:0]    req_chunk_len,
   input  logic [bbrm_pkg::RLEN_W-1:0]   req_take_len,
   input  logic [bbrm_pkg::MODE_W-1:0]   req_read_mode,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bbrm_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic [bbrm_pkg::RLEN_W-1:0]   rsp_read_count,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbrm_pkg::CAP_W-1:0]    csr_capacity_in_use
);

   import bbrm_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int RF_W   = (CNT_W > RUN_W) ? CNT_W : RUN_W;

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [RUN_W-1:0]  run_idx_ff, run_idx_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [BYTE_W-1:0] wr_byte_ff, wr_byte_in;
   logic              wr_discard_ff, wr_discard_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              byte_valid_ff, byte_valid_in;
   logic              last_ff, last_in;
   logic [RLEN_W-1:0] count_ff, count_in;

   logic              req_xfer;
   logic              rsp_xfer;
   logic [CMP_W-1:0]  cap_w;
   logic [CMP_W-1:0]  fill_w;
   logic [CMP_W-1:0]  room_w;
   logic [RUN_W-1:0]  rlen_clip;
   logic [CNT_W-1:0]  eff_fill;
   logic [ADDR_W-1:0] eff_head;
   logic [SUM_W-1:0]  wr_sum;
   logic [RUN_W-1:0]  run_next;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;

   bbrm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_byte_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_SEND);
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_read_count = count_ff;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   assign cap_w  = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity_ff);
   assign fill_w = CMP_W'(fill_ff);
   assign room_w = (fill_w < cap_w) ? (cap_w - fill_w) : '0;

   assign rlen_clip = (req_take_len > RLEN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                        : RUN_W'(req_take_len);

   assign eff_fill    = wr_discard_ff ? '0 : fill_ff;
   assign eff_head    = wr_discard_ff ? '0 : head_ff;
   assign wr_sum      = SUM_W'(eff_head) + SUM_W'(eff_fill);
   assign ram_wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? ADDR_W'(wr_sum - SUM_W'(DEPTH))
                                                  : ADDR_W'(wr_sum);
   assign run_next    = run_idx_ff + RUN_W'(1);

   always_comb begin
      state_in      = state_ff;
      capacity_in   = capacity_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      rd_ptr_in     = rd_ptr_ff;
      run_len_in    = run_len_ff;
      run_idx_in    = run_idx_ff;
      mode_in       = mode_ff;
      wr_byte_in    = wr_byte_ff;
      wr_discard_in = wr_discard_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity_in_use;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_action)
                  ACT_WRITE: begin
                     wr_byte_in    = req_write_byte;
                     wr_discard_in = req_chunk_first && (CMP_W'(req_chunk_len) > room_w);
                     state_in      = ST_WRITE;
                  end
                  ACT_READ: begin
                     if (RF_W'(fill_ff) < RF_W'(rlen_clip)) begin
                        run_len_in = RUN_W'(fill_ff);
                     end else begin
                        run_len_in = rlen_clip;
                     end
                     run_idx_in = '0;
                     rd_ptr_in  = head_ff;
                     mode_in    = req_read_mode;
                     state_in   = ST_READ_ADDR;
                  end
                  ACT_CLEAR: begin
                     fill_in = '0;
                     head_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WRITE: begin
            head_in = eff_head;
            fill_in = eff_fill;
            if (CMP_W'(eff_fill) < cap_w) begin
               ram_wr_en = 1'b1;
               fill_in   = eff_fill + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end

         ST_READ_ADDR: begin
            if (run_len_ff == '0) begin
               out_byte_in   = '0;
               byte_valid_in = 1'b0;
               last_in       = 1'b1;
               count_in      = '0;
               state_in      = ST_SEND;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_READ_DATA;
            end
         end

         ST_READ_DATA: begin
            out_byte_in   = ram_rd_data;
            byte_valid_in = 1'b1;
            last_in       = (run_next == run_len_ff);
            count_in      = (run_next == run_len_ff) ? RLEN_W'(run_len_ff) : '0;
            run_idx_in    = run_next;
            if (rd_ptr_ff == ADDR_W'(DEPTH - 1)) begin
               rd_ptr_in = '0;
            end else begin
               rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
            end
            state_in = ST_SEND;
         end

         ST_SEND: begin
            if (rsp_xfer) begin
               if (!last_ff) begin
                  state_in = ST_READ_ADDR;
               end else begin
                  state_in = ST_IDLE;
                  if (byte_valid_ff) begin
                     case (mode_ff)
                        MODE_FULL: begin
                           fill_in = '0;
                           head_in = '0;
                        end
                        MODE_PARTIAL: begin
                           fill_in = fill_ff - CNT_W'(run_len_ff);
                           head_in = rd_ptr_ff;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         fill_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      run_len_ff    <= run_len_in;
      run_idx_ff    <= run_idx_in;
      mode_ff       <= mode_in;
      wr_byte_ff    <= wr_byte_in;
      wr_discard_ff <= wr_discard_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      count_ff      <= count_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
   else $error("fill count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
   else $error("request taken while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_read_count == '0 && rsp_out_byte == '0)
   else $error("malformed empty read result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid && rsp_last |-> rsp_read_count != '0
         && RF_W'(rsp_read_count) <= RF_W'(fill_ff))
   else $error("run count on final byte out of range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEND && byte_valid_ff |-> run_idx_ff <= run_len_ff && run_idx_ff != '0)
   else $error("run index outside the run");

endmodule
